>>> design/nsaw_pkg.sv
// ----------------------------------------------------------------------------
// nsaw_pkg
// Shared types and constants of the strided address walker: command and
// register codes, sequencer states and the control word of the shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nsaw_pkg;

  localparam int NUM_PTRS    = 3;   // pointers A, B, C
  localparam int STEP_W      = 32;
  localparam int BASE_W      = 32;
  localparam int OUT_POS_W   = 32;
  localparam int OUT_IDX_W   = 16;
  localparam int IN_SIZE_W   = 16;
  localparam int NUM_IDX_OUT = 4;
  localparam int CFG_W       = 3;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_START   = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS_IN_USE = 2'd0,
    CFG_AXIS_ORDER  = 2'd1,
    CFG_PTR_ENABLE  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_MUL  = 2'd2,
    ST_ACC  = 2'd3
  } state_e;

  typedef struct packed {
    logic load_base;
    logic mul_en;
    logic acc_en;
    logic sub;
  } mac_ctrl_t;

endpackage

`default_nettype wire

>>> design/nsaw_axis_store.sv
// ----------------------------------------------------------------------------
// nsaw_axis_store
// Per-axis size and step tables, written by a load transaction and read at
// the axis the sequencer is working on.
// ----------------------------------------------------------------------------
`default_nettype none

module nsaw_axis_store
  import nsaw_pkg::*;
#(
  parameter int MAX_DIMS  = 4,
  parameter int SIZE_BITS = 16,
  localparam int AX_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [AX_W-1:0]                     wr_axis_i,
  input  wire logic [SIZE_BITS-1:0]                wr_size_i,
  input  wire logic [NUM_PTRS-1:0][STEP_W-1:0]     wr_step_i,
  input  wire logic [AX_W-1:0]                     rd_axis_i,
  output logic      [SIZE_BITS-1:0]                rd_size_o,
  output logic      [NUM_PTRS-1:0][STEP_W-1:0]     rd_step_o
);

  logic [SIZE_BITS-1:0]            size_q [MAX_DIMS];
  logic [NUM_PTRS-1:0][STEP_W-1:0] step_q [MAX_DIMS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      size_q[wr_axis_i] <= wr_size_i;
      step_q[wr_axis_i] <= wr_step_i;
    end
  end

  assign rd_size_o = size_q[rd_axis_i];
  assign rd_step_o = step_q[rd_axis_i];

endmodule

`default_nettype wire

>>> design/nsaw_mac.sv
// ----------------------------------------------------------------------------
// nsaw_mac
// Shared multiply-accumulate unit: one lane per pointer, multiplies an index
// by the axis step, then adds the product to or subtracts it from the
// pointer position. Positions wrap modulo 2^POS_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module nsaw_mac
  import nsaw_pkg::*;
#(
  parameter int SIZE_BITS = 16,
  parameter int POS_BITS  = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mac_ctrl_t                           ctrl_i,
  input  wire logic [NUM_PTRS-1:0]                 ptr_en_i,
  input  wire logic [NUM_PTRS-1:0][BASE_W-1:0]     base_i,
  input  wire logic [NUM_PTRS-1:0][STEP_W-1:0]     step_i,
  input  wire logic [SIZE_BITS-1:0]                mult_i,
  output logic      [NUM_PTRS-1:0][POS_BITS-1:0]   pos_o
);

  localparam int PROD_W = SIZE_BITS + 1 + STEP_W;
  localparam int EXT_W  = (PROD_W > POS_BITS) ? PROD_W : POS_BITS;

  logic signed [SIZE_BITS:0] mult_s;

  assign mult_s = signed'({1'b0, mult_i});

  for (genvar p = 0; p < NUM_PTRS; p++) begin : g_lane
    logic signed [STEP_W-1:0]  step_s;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [EXT_W-1:0]   prod_ext;
    logic        [POS_BITS-1:0] prod_q;
    logic        [POS_BITS-1:0] pos_q;

    assign step_s    = signed'(step_i[p]);
    assign prod_full = mult_s * step_s;
    assign prod_ext  = EXT_W'(prod_full);

    always_ff @(posedge clk_i) begin
      if (ctrl_i.mul_en) begin
        prod_q <= prod_ext[POS_BITS-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q <= '0;
      end else if (ctrl_i.load_base) begin
        pos_q <= POS_BITS'(base_i[p]);
      end else if (ctrl_i.acc_en && ptr_en_i[p]) begin
        pos_q <= ctrl_i.sub ? (pos_q - prod_q) : (pos_q + prod_q);
      end
    end

    assign pos_o[p] = pos_q;
  end

endmodule

`default_nettype wire

>>> design/nsaw_seq.sv
// ----------------------------------------------------------------------------
// nsaw_seq
// Sequencer of the walker: holds the index tuple, visits the axes one at a
// time and drives the shared multiply-accumulate unit for each of them.
// ----------------------------------------------------------------------------
`default_nettype none

module nsaw_seq
  import nsaw_pkg::*;
#(
  parameter int MAX_DIMS  = 4,
  parameter int SIZE_BITS = 16,
  localparam int CNT_W    = $clog2(MAX_DIMS + 1),
  localparam int AX_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 accept_i,
  input  wire logic [1:0]                           command_i,
  input  wire logic                                 backward_i,
  input  wire logic [CNT_W-1:0]                     used_i,
  input  wire logic                                 axis_order_i,
  input  wire logic [SIZE_BITS-1:0]                 size_i,
  output logic      [AX_W-1:0]                      rd_axis_o,
  output mac_ctrl_t                                 mac_ctrl_o,
  output logic      [SIZE_BITS-1:0]                 mult_o,
  output logic                                      busy_o,
  output logic                                      valid_o,
  output logic                                      done_o,
  output logic                                      empty_o,
  output logic      [MAX_DIMS-1:0][SIZE_BITS-1:0]   index_o
);

  state_e                             state_q, state_d;
  logic [CNT_W-1:0]                   k_q, k_d;
  logic                               walk_back_q, walk_back_d;
  logic                               adv_q, adv_d;
  logic [SIZE_BITS-1:0]               mult_q, mult_d;
  logic                               sub_q, sub_d;
  logic                               last_q, last_d;
  logic                               done_q, done_d;
  logic                               empty_q, empty_d;
  logic                               strobe_q, strobe_d;
  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] index_q, index_d;

  logic [CNT_W-1:0]     rev_k;
  logic [AX_W-1:0]      ax;
  logic [SIZE_BITS-1:0] limit;
  logic [SIZE_BITS-1:0] cur_idx;
  logic                 finish;
  logic                 walk_cmd;

  // Fastest axis first: axis k, or counted down from the last used axis
  assign rev_k   = CNT_W'(used_i - k_q - 1'b1);
  assign ax      = axis_order_i ? AX_W'(rev_k) : AX_W'(k_q);
  assign limit   = (size_i == '0) ? '0 : SIZE_BITS'(size_i - 1'b1);
  assign cur_idx = index_q[ax];
  assign finish  = last_q || (CNT_W'(k_q + 1'b1) == used_i);
  assign walk_cmd = (command_i == CMD_START) || (command_i == CMD_ADVANCE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i && walk_cmd && (used_i != '0)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC: begin
        state_d = finish ? ST_IDLE : ST_EVAL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    k_d         = k_q;
    walk_back_d = walk_back_q;
    adv_d       = adv_q;
    mult_d      = mult_q;
    sub_d       = sub_q;
    last_d      = last_q;
    done_d      = done_q;
    empty_d     = empty_q;
    strobe_d    = 1'b0;
    index_d     = index_q;
    mac_ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          case (command_i)
            CMD_START: begin
              mac_ctrl_o.load_base = 1'b1;
              walk_back_d = backward_i;
              adv_d       = 1'b0;
              k_d         = '0;
              index_d     = '0;
              done_d      = 1'b0;
              empty_d     = 1'b0;
              strobe_d    = (used_i == '0);
            end
            CMD_ADVANCE: begin
              adv_d    = 1'b1;
              k_d      = '0;
              done_d   = (used_i == '0);
              empty_d  = 1'b0;
              strobe_d = (used_i == '0);
            end
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        if (!adv_q) begin
          if (size_i == '0) begin
            empty_d = 1'b1;
          end
          index_d[ax] = walk_back_q ? limit : '0;
          mult_d      = walk_back_q ? limit : '0;
          sub_d       = 1'b0;
          last_d      = 1'b0;
        end else if (!walk_back_q) begin
          if (cur_idx < limit) begin
            index_d[ax] = SIZE_BITS'(cur_idx + 1'b1);
            mult_d      = SIZE_BITS'(1);
            sub_d       = 1'b0;
            last_d      = 1'b1;
          end else begin
            // carry: take the whole run of this axis back off
            index_d[ax] = '0;
            mult_d      = cur_idx;
            sub_d       = 1'b1;
            last_d      = 1'b0;
          end
        end else begin
          if (cur_idx != '0) begin
            index_d[ax] = SIZE_BITS'(cur_idx - 1'b1);
            mult_d      = SIZE_BITS'(1);
            sub_d       = 1'b1;
            last_d      = 1'b1;
          end else begin
            index_d[ax] = limit;
            mult_d      = limit;
            sub_d       = 1'b0;
            last_d      = 1'b0;
          end
        end
      end
      ST_MUL: begin
        mac_ctrl_o.mul_en = 1'b1;
      end
      ST_ACC: begin
        mac_ctrl_o.acc_en = 1'b1;
        mac_ctrl_o.sub    = sub_q;
        if (finish) begin
          strobe_d = 1'b1;
          done_d   = adv_q && !last_q;
        end else begin
          k_d = CNT_W'(k_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      walk_back_q <= 1'b0;
      adv_q       <= 1'b0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
      empty_q     <= 1'b0;
      strobe_q    <= 1'b0;
      index_q     <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      walk_back_q <= walk_back_d;
      adv_q       <= adv_d;
      last_q      <= last_d;
      done_q      <= done_d;
      empty_q     <= empty_d;
      strobe_q    <= strobe_d;
      index_q     <= index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mult_q <= mult_d;
    sub_q  <= sub_d;
  end

  assign rd_axis_o = ax;
  assign mult_o    = mult_q;
  assign busy_o    = (state_q != ST_IDLE);
  assign valid_o   = strobe_q;
  assign done_o    = done_q;
  assign empty_o   = empty_q;
  assign index_o   = index_q;

  // A result only appears once the walk has handed back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> !(done_q && empty_q))
    else $error("done and empty raised together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (k_q < used_i))
    else $error("axis counter beyond used axes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && last_q) |=> (strobe_q && !done_q))
    else $error("settled step did not give a plain result");

endmodule

`default_nettype wire

>>> design/nd_strided_address_walker.sv
// ----------------------------------------------------------------------------
// nd_strided_address_walker
// Odometer-style address generator for an N-dimensional strided array with
// three tracked pointers, built around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Load: taken when idle, no result, busy stays low.
// Start / advance: each axis visited goes through evaluate, multiply and
//   accumulate while busy is high; the result is strobed for one cycle
//   once the walk is back in idle (all used axes for start, 1..used for
//   advance; with no axes in use the result comes in the very next cycle).
//   A new command can be taken in the strobe cycle. Results cannot be stalled.
// Reset: index tuple, positions and walk direction cleared; registers at
//   their defaults (no axes, axis 0 fastest, all pointers tracked).
`default_nettype none

module nd_strided_address_walker
  import nsaw_pkg::*;
#(
  parameter int MAX_DIMS  = 4,
  parameter int SIZE_BITS = 16,
  parameter int POS_BITS  = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             command_i,
  input  wire logic [1:0]             axis_i,
  input  wire logic [IN_SIZE_W-1:0]   axis_size_i,
  input  wire logic [STEP_W-1:0]      step_a_i,
  input  wire logic [STEP_W-1:0]      step_b_i,
  input  wire logic [STEP_W-1:0]      step_c_i,
  input  wire logic [BASE_W-1:0]      base_a_i,
  input  wire logic [BASE_W-1:0]      base_b_i,
  input  wire logic [BASE_W-1:0]      base_c_i,
  input  wire logic                   backward_i,
  output logic                        valid_o,
  output logic [OUT_POS_W-1:0]        pos_a_o,
  output logic [OUT_POS_W-1:0]        pos_b_o,
  output logic [OUT_POS_W-1:0]        pos_c_o,
  output logic [OUT_IDX_W-1:0]        index_0_o,
  output logic [OUT_IDX_W-1:0]        index_1_o,
  output logic [OUT_IDX_W-1:0]        index_2_o,
  output logic [OUT_IDX_W-1:0]        index_3_o,
  output logic                        done_res_o,
  output logic                        empty_res_o
);

  localparam int CNT_W = $clog2(MAX_DIMS + 1);
  localparam int AX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [CFG_W-1:0]    dims_q;
  logic                order_q;
  logic [NUM_PTRS-1:0] ptr_en_q;

  logic                               accept;
  logic                               load_we;
  logic [CNT_W-1:0]                   used;
  logic [AX_W-1:0]                    rd_axis;
  logic [SIZE_BITS-1:0]               rd_size;
  logic [NUM_PTRS-1:0][STEP_W-1:0]    rd_step;
  logic [NUM_PTRS-1:0][STEP_W-1:0]    wr_step;
  logic [NUM_PTRS-1:0][BASE_W-1:0]    bases;
  logic [NUM_PTRS-1:0][POS_BITS-1:0]  pos;
  logic [SIZE_BITS-1:0]               mult;
  mac_ctrl_t                          mac_ctrl;
  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] index;
  logic [NUM_IDX_OUT-1:0][OUT_IDX_W-1:0] index_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q   <= '0;
      order_q  <= 1'b0;
      ptr_en_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIMS_IN_USE: dims_q   <= cfg_wdata_i;
        CFG_AXIS_ORDER:  order_q  <= cfg_wdata_i[0];
        CFG_PTR_ENABLE:  ptr_en_q <= cfg_wdata_i[NUM_PTRS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the axis count to what the tables hold
  assign used = ({1'b0, dims_q} > 4'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : CNT_W'(dims_q);

  assign accept  = start && !busy;
  assign load_we = accept && (command_i == CMD_LOAD) && ({2'b00, axis_i} < 4'(MAX_DIMS));
  assign wr_step = {step_c_i, step_b_i, step_a_i};
  assign bases   = {base_c_i, base_b_i, base_a_i};

  nsaw_axis_store #(
    .MAX_DIMS  (MAX_DIMS),
    .SIZE_BITS (SIZE_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .wr_axis_i (AX_W'(axis_i)),
    .wr_size_i (SIZE_BITS'(axis_size_i)),
    .wr_step_i (wr_step),
    .rd_axis_i (rd_axis),
    .rd_size_o (rd_size),
    .rd_step_o (rd_step)
  );

  nsaw_seq #(
    .MAX_DIMS  (MAX_DIMS),
    .SIZE_BITS (SIZE_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .backward_i   (backward_i),
    .used_i       (used),
    .axis_order_i (order_q),
    .size_i       (rd_size),
    .rd_axis_o    (rd_axis),
    .mac_ctrl_o   (mac_ctrl),
    .mult_o       (mult),
    .busy_o       (busy),
    .valid_o      (valid_o),
    .done_o       (done_res_o),
    .empty_o      (empty_res_o),
    .index_o      (index)
  );

  nsaw_mac #(
    .SIZE_BITS (SIZE_BITS),
    .POS_BITS  (POS_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .ptr_en_i (ptr_en_q),
    .base_i   (bases),
    .step_i   (rd_step),
    .mult_i   (mult),
    .pos_o    (pos)
  );

  assign pos_a_o = OUT_POS_W'(pos[0]);
  assign pos_b_o = OUT_POS_W'(pos[1]);
  assign pos_c_o = OUT_POS_W'(pos[2]);

  for (genvar i = 0; i < NUM_IDX_OUT; i++) begin : g_idx
    if (i < MAX_DIMS) begin : g_used
      assign index_out[i] = OUT_IDX_W'(index[i]);
    end else begin : g_none
      assign index_out[i] = '0;
    end
  end

  assign index_0_o = index_out[0];
  assign index_1_o = index_out[1];
  assign index_2_o = index_out[2];
  assign index_3_o = index_out[3];

endmodule

`default_nettype wire

>>> bench/address_walk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// address_walk_checker
// Observes the register port, the command channel and the result strobe of
// the strided address walker. Keeps its own copy of the size and step tables,
// the index tuple and the three positions, works out the result that each
// accepted start or advance should give, and compares the results in order.
// ----------------------------------------------------------------------------
module address_walk_checker
  import nsaw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [1:0]           command_i,
  input  logic [1:0]           axis_i,
  input  logic [IN_SIZE_W-1:0] axis_size_i,
  input  logic [STEP_W-1:0]    step_a_i,
  input  logic [STEP_W-1:0]    step_b_i,
  input  logic [STEP_W-1:0]    step_c_i,
  input  logic [BASE_W-1:0]    base_a_i,
  input  logic [BASE_W-1:0]    base_b_i,
  input  logic [BASE_W-1:0]    base_c_i,
  input  logic                 backward_i,
  input  logic                 valid_i,
  input  logic [OUT_POS_W-1:0] pos_a_i,
  input  logic [OUT_POS_W-1:0] pos_b_i,
  input  logic [OUT_POS_W-1:0] pos_c_i,
  input  logic [OUT_IDX_W-1:0] index_0_i,
  input  logic [OUT_IDX_W-1:0] index_1_i,
  input  logic [OUT_IDX_W-1:0] index_2_i,
  input  logic [OUT_IDX_W-1:0] index_3_i,
  input  logic                 done_res_i,
  input  logic                 empty_res_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int AXES = 4;

  typedef struct packed {
    logic [OUT_POS_W-1:0] pos_a;
    logic [OUT_POS_W-1:0] pos_b;
    logic [OUT_POS_W-1:0] pos_c;
    logic [OUT_IDX_W-1:0] index_0;
    logic [OUT_IDX_W-1:0] index_1;
    logic [OUT_IDX_W-1:0] index_2;
    logic [OUT_IDX_W-1:0] index_3;
    logic                 done;
    logic                 empty;
  } walk_point_t;

  logic [2:0]           dims_reg;
  logic                 order_reg;
  logic [2:0]           ptr_en_reg;
  logic                 walk_back;
  logic [IN_SIZE_W-1:0] size_tbl [AXES];
  logic [STEP_W-1:0]    step_tbl [NUM_PTRS][AXES];
  logic [OUT_IDX_W-1:0] idx_q    [AXES];
  logic [OUT_POS_W-1:0] pos_q    [NUM_PTRS];

  walk_point_t walk_points_q [$];

  function automatic int used_axes();
    return (dims_reg > AXES) ? AXES : int'(dims_reg);
  endfunction

  function automatic int axis_of(int k, int d);
    return order_reg ? d - 1 - k : k;
  endfunction

  // a size-zero axis behaves as a single element
  function automatic logic [OUT_IDX_W-1:0] top_index(int i);
    return (size_tbl[i] == '0) ? '0 : size_tbl[i] - 1'b1;
  endfunction

  function automatic void shift_pointers(int i, logic [OUT_IDX_W-1:0] mult, bit sub);
    logic [OUT_POS_W-1:0] delta;
    for (int p = 0; p < NUM_PTRS; p++) begin
      delta = {16'b0, mult} * step_tbl[p][i];
      if (ptr_en_reg[p]) pos_q[p] = sub ? pos_q[p] - delta : pos_q[p] + delta;
    end
  endfunction

  // move the tuple by one element; returns 1 when every axis wrapped
  function automatic bit advance_tuple(int d);
    int i;
    for (int k = 0; k < d; k++) begin
      i = axis_of(k, d);
      if (walk_back) begin
        if (idx_q[i] > 0) begin
          idx_q[i] = idx_q[i] - 1'b1;
          shift_pointers(i, 16'd1, 1'b1);
          return 1'b0;
        end
        idx_q[i] = top_index(i);
        shift_pointers(i, idx_q[i], 1'b0);
      end else begin
        // an index above its limit after a reload carries too
        if (idx_q[i] < top_index(i)) begin
          idx_q[i] = idx_q[i] + 1'b1;
          shift_pointers(i, 16'd1, 1'b0);
          return 1'b0;
        end
        shift_pointers(i, idx_q[i], 1'b1);
        idx_q[i] = '0;
      end
    end
    return 1'b1;
  endfunction

  function automatic walk_point_t make_point(logic done_f, logic empty_f);
    walk_point_t pt;
    pt.pos_a   = pos_q[0];
    pt.pos_b   = pos_q[1];
    pt.pos_c   = pos_q[2];
    pt.index_0 = idx_q[0];
    pt.index_1 = idx_q[1];
    pt.index_2 = idx_q[2];
    pt.index_3 = idx_q[3];
    pt.done    = done_f;
    pt.empty   = empty_f;
    return pt;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    walk_point_t want;
    logic        empty_f;
    if (!rst_ni) begin
      dims_reg   = '0;
      order_reg  = 1'b0;
      ptr_en_reg = 3'b111;
      walk_back  = 1'b0;
      for (int i = 0; i < AXES; i++) begin
        size_tbl[i] = '0;
        idx_q[i]    = '0;
        for (int p = 0; p < NUM_PTRS; p++) step_tbl[p][i] = '0;
      end
      for (int p = 0; p < NUM_PTRS; p++) pos_q[p] = '0;
      walk_points_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first: a result never belongs to a command taken at the same edge
      if (valid_i) begin
        if (walk_points_q.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          fail_count_o++;
        end else begin
          want = walk_points_q.pop_front();
          check_field("pos_a",     want.pos_a,   pos_a_i);
          check_field("pos_b",     want.pos_b,   pos_b_i);
          check_field("pos_c",     want.pos_c,   pos_c_i);
          check_field("index_0",   want.index_0, index_0_i);
          check_field("index_1",   want.index_1, index_1_i);
          check_field("index_2",   want.index_2, index_2_i);
          check_field("index_3",   want.index_3, index_3_i);
          check_field("done_res",  want.done,    done_res_i);
          check_field("empty_res", want.empty,   empty_res_i);
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DIMS_IN_USE: dims_reg   = cfg_wdata_i;
          CFG_AXIS_ORDER:  order_reg  = cfg_wdata_i[0];
          CFG_PTR_ENABLE:  ptr_en_reg = cfg_wdata_i;
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        case (command_i)
          CMD_LOAD: begin
            size_tbl[axis_i]    = axis_size_i;
            step_tbl[0][axis_i] = step_a_i;
            step_tbl[1][axis_i] = step_b_i;
            step_tbl[2][axis_i] = step_c_i;
          end
          CMD_START: begin
            walk_back = backward_i;
            pos_q[0]  = base_a_i;
            pos_q[1]  = base_b_i;
            pos_q[2]  = base_c_i;
            empty_f   = 1'b0;
            for (int i = 0; i < AXES; i++) begin
              idx_q[i] = '0;
              if (i < used_axes()) begin
                if (size_tbl[i] == '0) empty_f = 1'b1;
                if (walk_back) idx_q[i] = top_index(i);
                shift_pointers(i, idx_q[i], 1'b0);
              end
            end
            walk_points_q.push_back(make_point(1'b0, empty_f));
          end
          CMD_ADVANCE: begin
            walk_points_q.push_back(make_point(advance_tuple(used_axes()), 1'b0));
          end
          default: ;
        endcase
      end
      pending_o = walk_points_q.size();
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the strided address walker with a short directed run over the edge
// cases and then with random load / start / advance walks under a series of
// register settings and sender idling patterns. The checker beside the block
// predicts and compares; this module only makes stimulus and gives a verdict.
// ----------------------------------------------------------------------------
module testbench;
  import nsaw_pkg::*;

  // settings, packed three bits each, setting 0 in the low bits
  localparam logic [35:0] DIMS_SET = {3'd2, 3'd3, 3'd4, 3'd6, 3'd5, 3'd4,
                                      3'd3, 3'd2, 3'd7, 3'd1, 3'd0, 3'd4};
  localparam logic [35:0] EN_SET   = {3'd7, 3'd0, 3'd7, 3'd3, 3'd6, 3'd4,
                                      3'd1, 3'd7, 3'd2, 3'd5, 3'd0, 3'd7};

  // codes outside the defined sets, to exercise the drop paths
  localparam logic [1:0]           CMD_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 start     = 1'b0;
  logic                 busy;
  logic [1:0]           command   = '0;
  logic [1:0]           axis      = '0;
  logic [IN_SIZE_W-1:0] axis_size = '0;
  logic [STEP_W-1:0]    step_a    = '0;
  logic [STEP_W-1:0]    step_b    = '0;
  logic [STEP_W-1:0]    step_c    = '0;
  logic [BASE_W-1:0]    base_a    = '0;
  logic [BASE_W-1:0]    base_b    = '0;
  logic [BASE_W-1:0]    base_c    = '0;
  logic                 backward  = 1'b0;
  logic                 valid;
  logic [OUT_POS_W-1:0] pos_a, pos_b, pos_c;
  logic [OUT_IDX_W-1:0] index_0, index_1, index_2, index_3;
  logic                 done_res, empty_res;
  int                   fail_count;
  int                   pending;

  int                   gap_pct    = 6;
  int                   items_sent = 0;
  int                   cur_axes   = 0;
  logic [IN_SIZE_W-1:0] sizes_loaded [4];

  always #5 clk_i = ~clk_i;

  nd_strided_address_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .command_i   (command),
    .axis_i      (axis),
    .axis_size_i (axis_size),
    .step_a_i    (step_a),
    .step_b_i    (step_b),
    .step_c_i    (step_c),
    .base_a_i    (base_a),
    .base_b_i    (base_b),
    .base_c_i    (base_c),
    .backward_i  (backward),
    .valid_o     (valid),
    .pos_a_o     (pos_a),
    .pos_b_o     (pos_b),
    .pos_c_o     (pos_c),
    .index_0_o   (index_0),
    .index_1_o   (index_1),
    .index_2_o   (index_2),
    .index_3_o   (index_3),
    .done_res_o  (done_res),
    .empty_res_o (empty_res)
  );

  address_walk_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .start_i      (start),
    .busy_i       (busy),
    .command_i    (command),
    .axis_i       (axis),
    .axis_size_i  (axis_size),
    .step_a_i     (step_a),
    .step_b_i     (step_b),
    .step_c_i     (step_c),
    .base_a_i     (base_a),
    .base_b_i     (base_b),
    .base_c_i     (base_c),
    .backward_i   (backward),
    .valid_i      (valid),
    .pos_a_i      (pos_a),
    .pos_b_i      (pos_b),
    .pos_c_i      (pos_c),
    .index_0_i    (index_0),
    .index_1_i    (index_1),
    .index_2_i    (index_2),
    .index_3_i    (index_3),
    .done_res_i   (done_res),
    .empty_res_i  (empty_res),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_base();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly short axes so that walks wrap; now and then empty or huge ones
  function automatic logic [IN_SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)  return '0;
    if (r < 10) return 16'hffff;
    if (r < 14) return IN_SIZE_W'($urandom);
    return IN_SIZE_W'($urandom_range(1, 4));
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [1:0] ax,
                          input logic [IN_SIZE_W-1:0] sz,
                          input logic [31:0] sa, input logic [31:0] sb,
                          input logic [31:0] sc, input logic [31:0] ba,
                          input logic [31:0] bb, input logic [31:0] bc,
                          input logic back);
    @(negedge clk_i);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    start     <= 1'b1;
    command   <= cmd;
    axis      <= ax;
    axis_size <= sz;
    step_a    <= sa;
    step_b    <= sb;
    step_c    <= sc;
    base_a    <= ba;
    base_b    <= bb;
    base_c    <= bc;
    backward  <= back;
    if (cmd == CMD_LOAD) sizes_loaded[ax] = sz;
    if (cmd != CMD_UNKNOWN) items_sent++;
    // hold until the transaction is taken
    do begin
      @(posedge clk_i);
    end while (busy);
  endtask

  task automatic load_axis(input logic [1:0] ax, input logic [IN_SIZE_W-1:0] sz);
    send_cmd(CMD_LOAD, ax, sz, rand_step(), rand_step(), rand_step(),
             $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic advance_once();
    send_cmd(CMD_ADVANCE, 2'($urandom_range(0, 3)), IN_SIZE_W'($urandom), $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom,
             1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    wait (pending == 0);
    // a trailing load or ignored command may still be in flight
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apply_setting(input int s);
    logic [2:0] dims;
    logic [2:0] order_val;
    dims      = DIMS_SET[s*3 +: 3];
    order_val = 3'(($urandom_range(0, 3) << 1) | (s % 2));
    write_reg(CFG_DIMS_IN_USE, dims);
    write_reg(CFG_AXIS_ORDER, order_val);
    write_reg(CFG_PTR_ENABLE, EN_SET[s*3 +: 3]);
    cur_axes = (dims > 4) ? 4 : int'(dims);
  endtask

  // reload some axes, start, then walk to the end or part of the way
  task automatic run_walk();
    int n_loads;
    int prod;
    int total;
    n_loads = $urandom_range(0, 3);
    for (int k = 0; k < n_loads; k++) load_axis(2'($urandom_range(0, 3)), rand_size());
    send_cmd(CMD_START, 2'($urandom_range(0, 3)), IN_SIZE_W'($urandom), $urandom,
             $urandom, $urandom, rand_base(), rand_base(), rand_base(),
             1'($urandom_range(0, 1)));
    prod = 1;
    for (int i = 0; i < cur_axes; i++) begin
      prod = prod * ((sizes_loaded[i] == 0) ? 1 : int'(sizes_loaded[i]));
      if (prod > 48) prod = 48;
    end
    total = ($urandom_range(0, 9) < 7) ? prod + 1 : int'($urandom_range(1, prod));
    for (int n = 0; n < total; n++) begin
      if (n == total / 2 && $urandom_range(0, 9) == 0)
        load_axis(2'($urandom_range(0, 3)), rand_size());
      advance_once();
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 6))
      send_cmd(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), IN_SIZE_W'($urandom),
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               1'($urandom_range(0, 1)));
  endtask

  initial begin
    int target;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill every axis entry first, so no walk reads an unloaded one
    send_cmd(CMD_LOAD, 2'd0, 16'd3, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 0, 0, 0, 1'b0);
    send_cmd(CMD_LOAD, 2'd1, 16'hffff, 32'hffff_ffff, 32'd0, 32'h8000_0000,
             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_cmd(CMD_LOAD, 2'd2, 16'd0, 32'd5, 32'hffff_fffe, 32'h7fff_ffff, 0, 0, 0, 1'b0);
    send_cmd(CMD_LOAD, 2'd3, 16'd2, 32'h100, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 1'b0);
    // no axes in use: start gives the bases, advance reports the walk done
    send_cmd(CMD_START, 2'd0, 16'd0, 0, 0, 0, 32'hffff_ffff, 32'd0, 32'h8000_0000, 1'b0);
    send_cmd(CMD_ADVANCE, 2'd0, 16'd0, 0, 0, 0, 0, 0, 0, 1'b0);
    // unknown command: dropped without a result
    send_cmd(CMD_UNKNOWN, 2'd3, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    settle();
    write_reg(CFG_DIMS_IN_USE, 3'd4);
    write_reg(CFG_AXIS_ORDER, 3'b110);
    write_reg(CFG_PTR_ENABLE, 3'b111);
    write_reg(CFG_UNUSED, 3'b111);
    cur_axes = 4;
    // empty array, forward then backward from the top corner
    send_cmd(CMD_START, 2'd0, 16'd0, 0, 0, 0, 32'h1234_5678, 32'hffff_ffff, 32'd0, 1'b0);
    repeat (4) advance_once();
    send_cmd(CMD_START, 2'd0, 16'd0, 0, 0, 0, 32'h8000_0000, 32'd7, 32'hffff_ffff, 1'b1);
    repeat (3) advance_once();
    settle();
    write_reg(CFG_DIMS_IN_USE, 3'd7);
    write_reg(CFG_AXIS_ORDER, 3'b001);
    write_reg(CFG_PTR_ENABLE, 3'b101);
    cur_axes = 4;
    send_cmd(CMD_LOAD, 2'd2, 16'd2, 32'd9, 32'h8000_0001, 32'hffff_fff0, 0, 0, 0, 1'b0);
    send_cmd(CMD_START, 2'd0, 16'd0, 0, 0, 0, 32'h0000_0010, 32'hffff_ff00, 32'd3, 1'b0);
    repeat (3) advance_once();
    // shrink the slowest axis mid-walk to a single element
    send_cmd(CMD_LOAD, 2'd0, 16'd1, 32'hffff_fffd, 32'd4, 32'h4000_0000, 0, 0, 0, 1'b0);
    advance_once();
    send_cmd(CMD_START, 2'd0, 16'd0, 0, 0, 0, 32'hdead_0000, 32'd1, 32'hffff_ffff, 1'b1);
    advance_once();

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 6 : (ph == 1) ? 65 : 0;
      for (int s = 0; s < 4; s++) begin
        settle();
        apply_setting(ph * 4 + s);
        target = items_sent + 140;
        while (items_sent < target) begin
          if ($urandom_range(0, 99) < 80) run_walk();
          else run_noise();
        end
      end
    end

    settle();
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
design/nsaw_pkg.sv
design/nsaw_axis_store.sv
design/nsaw_mac.sv
design/nsaw_seq.sv
design/nd_strided_address_walker.sv
bench/address_walk_checker.sv
bench/testbench.sv
